@@ rtl/rfp_pkg.sv @@
// rfp_pkg: types, codes and digit weights for the rangefinder reply parser
// no dependencies; imported by rfp_frame, rangefinder_reply_parser and rfp_checker
`timescale 1ns / 1ps
`default_nettype none

package rfp_pkg;

    // reply status codes
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_TIMEOUT     = 3'd1,
        ST_NO_HEADER   = 3'd2,
        ST_WRONG_MSG   = 3'd3,
        ST_CALC_ERR    = 3'd4,
        ST_WEAK        = 3'd5,
        ST_STRONG      = 3'd6,
        ST_UNKNOWN_ERR = 3'd7
    } status_t;

    localparam int DIST_W   = 21;
    localparam int ERR_W    = 11;
    localparam int OFFSET_W = 4;
    localparam int LIMIT_W  = 16;

    localparam logic [7:0] HEADER_BYTE   = 8'hAA;
    localparam logic [7:0] MESSAGE_BYTE  = 8'h44;
    localparam logic [7:0] ERR_FLAG_BYTE = 8'h45;   // ascii 'E'

    localparam logic [OFFSET_W-1:0] MSG_OFFSET  = 4'd2;
    localparam logic [OFFSET_W-1:0] FLAG_OFFSET = 4'd3;
    localparam logic [OFFSET_W-1:0] LAST_OFFSET = 4'd8;
    localparam logic [OFFSET_W-1:0] SAT_OFFSET  = 4'd9;

    localparam logic [ERR_W-1:0] ERR_NUM_CALC   = 11'd204;
    localparam logic [ERR_W-1:0] ERR_NUM_WEAK   = 11'd255;
    localparam logic [ERR_W-1:0] ERR_NUM_STRONG = 11'd256;

    localparam logic [LIMIT_W-1:0] TIMEOUT_RESET = 16'd2000;

    // frame summary after one byte
    typedef struct packed {
        logic                header_found;
        logic [OFFSET_W-1:0] offset;
        logic [7:0]          message_byte;
        logic                error_flag_seen;
        logic [DIST_W-1:0]   distance_acc;
        logic [ERR_W-1:0]    error_acc;
    } frame_t;

    // decimal weight of a distance digit by offset from header
    function automatic logic [16:0] dist_weight(input logic [OFFSET_W-1:0] off);
        logic [16:0] w;
        case (off)
            4'd3:    w = 17'd100000;
            4'd4:    w = 17'd10000;
            4'd5:    w = 17'd1000;
            4'd6:    w = 17'd100;
            4'd7:    w = 17'd10;
            4'd8:    w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

    // decimal weight of an error-number digit by offset from header
    function automatic logic [6:0] err_weight(input logic [OFFSET_W-1:0] off);
        logic [6:0] w;
        case (off)
            4'd6:    w = 7'd100;
            4'd7:    w = 7'd10;
            4'd8:    w = 7'd1;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rfp_frame.sv @@
// rfp_frame: per-frame state (header search, offsets, digit accumulators)
// depends on rfp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rfp_frame
    import rfp_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       take_en,
    input  wire logic [7:0] rx_byte,
    input  wire logic       last_byte,
    output frame_t          frame_next
);

    localparam int POS_W = $clog2(BUFFER_BYTES + 1);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    frame_t           frame_reg;

    logic [OFFSET_W-1:0] off_inc;
    logic [3:0]          nib;
    logic [DIST_W-1:0]   dist_add;
    logic [ERR_W-1:0]    err_add;

    assign nib      = rx_byte[3:0];
    assign off_inc  = (frame_reg.offset < SAT_OFFSET) ? frame_reg.offset + 4'd1
                                                      : frame_reg.offset;
    assign dist_add = {17'd0, nib} * {4'd0, dist_weight(off_inc)};
    assign err_add  = {7'd0, nib} * {4'd0, err_weight(off_inc)};

    always_comb begin
        frame_next = frame_reg;
        pos_next   = pos_reg;
        if (pos_reg < POS_W'(BUFFER_BYTES)) begin
            pos_next = pos_reg + 1'b1;
            if (!frame_reg.header_found) begin
                if (rx_byte == HEADER_BYTE) begin
                    frame_next.header_found = 1'b1;
                    frame_next.offset       = '0;
                end
            end else begin
                frame_next.offset = off_inc;
                if (off_inc <= LAST_OFFSET) begin
                    if (off_inc == MSG_OFFSET) begin
                        frame_next.message_byte = rx_byte;
                    end
                    if (off_inc == FLAG_OFFSET) begin
                        frame_next.error_flag_seen = (rx_byte == ERR_FLAG_BYTE);
                    end
                    frame_next.distance_acc = frame_reg.distance_acc + dist_add;
                    frame_next.error_acc    = frame_reg.error_acc + err_add;
                end
            end
        end
    end

    // start over after the last byte of a frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            frame_reg <= '0;
        end else if (take_en) begin
            if (last_byte) begin
                pos_reg   <= '0;
                frame_reg <= '0;
            end else begin
                pos_reg   <= pos_next;
                frame_reg <= frame_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/rangefinder_reply_parser.sv @@
// rangefinder_reply_parser: top level, byte-wise reply frame parser
// depends on rfp_pkg and rfp_frame
`timescale 1ns / 1ps
`default_nettype none

// channel   | ports                                         | direction
// ----------+-----------------------------------------------+----------
// input     | s_valid s_ready s_rx_byte s_last_byte s_elapsed_ms | in
// result    | m_valid m_ready m_status m_distance_mm m_error_detail | out
// config    | cfg_wr_en cfg_wr_data (timeout limit, ms)     | in
//
// one byte per cycle sustained while no result stalls on m_ready; a result leaves
// the output register after its last byte passes the input register and then the result register
// the pace is set by the frame state update in rfp_frame, one add per byte
// aresetn is synchronous; it clears both valid flags, the frame state and
// sets the timeout limit to 2000 ms
// a result waiting on m_ready holds only a following last byte; other bytes
// keep flowing into the frame state

module rangefinder_reply_parser
    import rfp_pkg::*;
#(
    parameter int BUFFER_BYTES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration
    input  wire logic               cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] cfg_wr_data,
    // input channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,
    input  wire logic               s_last_byte,
    input  wire logic [15:0]        s_elapsed_ms,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic [DIST_W-1:0]       m_distance_mm,
    output logic [ERR_W-1:0]        m_error_detail
);

    logic [LIMIT_W-1:0] timeout_limit_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [15:0] in_elapsed_reg;

    // result register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic [ERR_W-1:0]  out_detail_reg;

    logic    advance;
    frame_t  frame_next;
    status_t status_next;
    logic [DIST_W-1:0] dist_next;
    logic [ERR_W-1:0]  detail_next;

    // a byte moves on unless it would produce a result into a full, stalled slot
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_limit_reg <= TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_limit_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg    <= s_rx_byte;
            in_last_reg    <= s_last_byte;
            in_elapsed_reg <= s_elapsed_ms;
        end
    end

    // frame state, updated with every transferred byte
    rfp_frame #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take_en    (advance),
        .rx_byte    (in_byte_reg),
        .last_byte  (in_last_reg),
        .frame_next (frame_next)
    );

    // verdict on the frame including the current byte
    // priority: timeout, missing header, wrong message byte, error or distance
    always_comb begin
        status_next = ST_OK;
        dist_next   = '0;
        detail_next = '0;
        if (in_elapsed_reg > timeout_limit_reg) begin
            status_next = ST_TIMEOUT;
        end else if (!frame_next.header_found) begin
            status_next = ST_NO_HEADER;
        end else if (frame_next.message_byte != MESSAGE_BYTE) begin
            status_next = ST_WRONG_MSG;
            detail_next = {3'd0, frame_next.message_byte};
        end else if (frame_next.error_flag_seen) begin
            if (frame_next.error_acc == ERR_NUM_CALC) begin
                status_next = ST_CALC_ERR;
            end else if (frame_next.error_acc == ERR_NUM_WEAK) begin
                status_next = ST_WEAK;
            end else if (frame_next.error_acc == ERR_NUM_STRONG) begin
                status_next = ST_STRONG;
            end else begin
                status_next = ST_UNKNOWN_ERR;
                detail_next = frame_next.error_acc;
            end
        end else begin
            dist_next = frame_next.distance_acc;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_status_reg <= status_next;
            out_dist_reg   <= dist_next;
            out_detail_reg <= detail_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_distance_mm  = out_dist_reg;
    assign m_error_detail = out_detail_reg;

endmodule

`default_nettype wire

@@ rtl/rfp_checker.sv @@
// rfp_checker: port-level assertions for rangefinder_reply_parser, with bind
// depends on rfp_pkg and rangefinder_reply_parser
`timescale 1ns / 1ps
`default_nettype none

module rfp_checker
    import rfp_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [2:0]        m_status,
    input wire logic [DIST_W-1:0] m_distance_mm,
    input wire logic [ERR_W-1:0]  m_error_detail
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_distance_mm) && $stable(m_error_detail))
        else $error("result changed while stalled");

    a_dist_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_distance_mm == '0)
        else $error("distance on a non-ok result");

    a_detail_only_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_WRONG_MSG && m_status != ST_UNKNOWN_ERR
            |-> m_error_detail == '0)
        else $error("detail on a status that carries none");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rangefinder_reply_parser rfp_checker u_rfp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_distance_mm  (m_distance_mm),
    .m_error_detail (m_error_detail)
);

`default_nettype wire

@@ sim/tb_rangefinder_reply_parser.sv @@
// tb_rangefinder_reply_parser: self-checking testbench for the rangefinder reply parser
// depends on rfp_pkg and rangefinder_reply_parser; byte frames in, parsed replies checked
`timescale 1ns / 1ps

module tb_rangefinder_reply_parser;
    import rfp_pkg::*;

    localparam int FRAME_BUF      = 64;
    localparam int SETTLE_CYCLES  = 8;       // input and result registers plus margin
    localparam int DRAIN_CAP      = 20000;
    localparam int PRINT_CAP      = 200;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    typedef struct {
        status_t           status;
        logic [DIST_W-1:0] dist_mm;
        logic [ERR_W-1:0]  detail;
    } reply_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [LIMIT_W-1:0] cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               s_last_byte;
    logic [15:0]        s_elapsed_ms;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic [DIST_W-1:0]  m_distance_mm;
    logic [ERR_W-1:0]   m_error_detail;

    // expected replies, oldest first
    reply_t pending_replies[$];

    // mirror of the parser's frame state and timeout register
    int                  frame_pos   = 0;
    bit                  hdr_seen    = 1'b0;
    logic [OFFSET_W-1:0] hdr_offset  = '0;
    logic [7:0]          msg_byte    = '0;
    bit                  err_flag    = 1'b0;
    logic [DIST_W-1:0]   dist_sum    = '0;
    logic [ERR_W-1:0]    err_sum     = '0;
    logic [LIMIT_W-1:0]  limit_ms    = TIMEOUT_RESET;

    // sender and receiver pacing
    int  burst_left        = 0;
    bit  gaps_on           = 1'b1;
    int  ready_hold_cycles = 0;
    int  bytes_sent        = 0;
    int  replies_seen      = 0;
    int  mismatch_count    = 0;

    logic [7:0] tx_frame[$];

    rangefinder_reply_parser #(
        .BUFFER_BYTES (FRAME_BUF)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_last_byte    (s_last_byte),
        .s_elapsed_ms   (s_elapsed_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_distance_mm  (m_distance_mm),
        .m_error_detail (m_error_detail)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // fixed watchdog, far above the slowest legal run
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // reply predictor
    // ------------------------------------------------------------------

    // decimal weight of one nibble digit at a given offset past the header
    function automatic int unsigned digit_scale(logic [OFFSET_W-1:0] off, bit err_digits);
        int unsigned s;
        case (off)
            4'd3:    s = 100000;
            4'd4:    s = 10000;
            4'd5:    s = 1000;
            4'd6:    s = 100;
            4'd7:    s = 10;
            4'd8:    s = 1;
            default: s = 0;
        endcase
        // the error number only uses the last three digits
        if (err_digits && off < 4'd6) s = 0;
        return s;
    endfunction

    function automatic void clear_frame_state();
        frame_pos  = 0;
        hdr_seen   = 1'b0;
        hdr_offset = '0;
        msg_byte   = '0;
        err_flag   = 1'b0;
        dist_sum   = '0;
        err_sum    = '0;
    endfunction

    // fold one transferred byte into the frame state, queue a reply on the last byte
    function automatic void parse_byte(logic [7:0] b, logic last, logic [15:0] el);
        reply_t r;
        // bytes past the buffer leave the frame state unchanged; a last byte still ends the frame
        if (frame_pos < FRAME_BUF) begin
            frame_pos++;
            if (!hdr_seen) begin
                if (b == HEADER_BYTE) begin
                    hdr_seen   = 1'b1;
                    hdr_offset = '0;
                end
            end else begin
                if (hdr_offset < SAT_OFFSET) hdr_offset++;
                if (hdr_offset <= LAST_OFFSET) begin
                    if (hdr_offset == MSG_OFFSET) msg_byte = b;
                    if (hdr_offset == FLAG_OFFSET) err_flag = (b == ERR_FLAG_BYTE);
                    dist_sum = dist_sum + DIST_W'(b[3:0] * digit_scale(hdr_offset, 1'b0));
                    err_sum  = err_sum + ERR_W'(b[3:0] * digit_scale(hdr_offset, 1'b1));
                end
            end
        end
        if (!last) return;

        r.dist_mm = '0;
        r.detail  = '0;
        // priority: timeout, missing header, wrong message byte, then error or distance
        if (el > limit_ms) begin
            r.status = ST_TIMEOUT;
        end else if (!hdr_seen) begin
            r.status = ST_NO_HEADER;
        end else if (msg_byte != MESSAGE_BYTE) begin
            r.status = ST_WRONG_MSG;
            r.detail = ERR_W'(msg_byte);
        end else if (err_flag) begin
            if (err_sum == ERR_NUM_CALC) begin
                r.status = ST_CALC_ERR;
            end else if (err_sum == ERR_NUM_WEAK) begin
                r.status = ST_WEAK;
            end else if (err_sum == ERR_NUM_STRONG) begin
                r.status = ST_STRONG;
            end else begin
                r.status = ST_UNKNOWN_ERR;
                r.detail = err_sum;
            end
        end else begin
            r.status  = ST_OK;
            r.dist_mm = dist_sum;
        end
        pending_replies.push_back(r);
        clear_frame_state();
    endfunction

    // ------------------------------------------------------------------
    // reply checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < PRINT_CAP)
            $display("ERROR t=%0t reply %0d: %s got %0d expected %0d",
                     $realtime, replies_seen, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : reply_check
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("reply with nothing pending, status", m_status, 0);
            end else begin
                want = pending_replies.pop_front();
                if (m_status != want.status)
                    report_mismatch("status", m_status, want.status);
                if (m_distance_mm != want.dist_mm)
                    report_mismatch("distance_mm", m_distance_mm, want.dist_mm);
                if (m_error_detail != want.detail)
                    report_mismatch("error_detail", m_error_detail, want.detail);
            end
            replies_seen++;
        end
    end

    // ------------------------------------------------------------------
    // result side: segments of always-ready, random and periodic stalls,
    // plus a long hold-off on request from the pressure test
    // ------------------------------------------------------------------
    initial begin : receiver
        int seg_left;
        int mode;
        int period;
        int tick;
        seg_left = 0;
        mode     = 0;
        period   = 2;
        tick     = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                period   = $urandom_range(2, 5);
                seg_left = $urandom_range(20, 120);
            end
            seg_left--;
            tick++;
            if (ready_hold_cycles > 0) begin
                ready_hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= $urandom_range(0, 1);
                    2:       m_ready <= (tick % period) != 0;
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // offer one byte, wait for its transfer, then maybe drop valid for a gap
    task automatic send_byte(logic [7:0] b, logic last, logic [15:0] el);
        s_valid      <= 1'b1;
        s_rx_byte    <= b;
        s_last_byte  <= last;
        s_elapsed_ms <= el;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        parse_byte(b, last, el);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (gaps_on) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // elapsed time only matters on the last byte; the others get noise
    task automatic send_frame(logic [15:0] el);
        for (int i = 0; i < tx_frame.size(); i++) begin
            if (i == tx_frame.size() - 1)
                send_byte(tx_frame[i], 1'b1, el);
            else
                send_byte(tx_frame[i], 1'b0, 16'($urandom_range(0, 65535)));
        end
    endtask

    // must run in the time step of the last transfer
    task automatic drain_replies();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (pending_replies.size() != 0 && waited < DRAIN_CAP) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_replies.size() != 0) begin
            report_mismatch("replies never delivered, count", pending_replies.size(), 0);
            pending_replies.delete();
        end
        // frames without a reply may still sit in the input register
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_timeout_limit(logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limit_ms     = v;
    endtask

    // ascii decimal digits, most significant first
    function automatic void put_digits(int unsigned value, int n);
        int unsigned div;
        div = 1;
        for (int i = 1; i < n; i++) div *= 10;
        for (int i = 0; i < n; i++) begin
            tx_frame.push_back(ASCII_ZERO + 8'((value / div) % 10));
            div /= 10;
        end
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == HEADER_BYTE) b = 8'h55;
        return b;
    endfunction

    function automatic logic [15:0] pick_elapsed();
        int sel;
        sel = $urandom_range(0, 19);
        case (sel)
            0:       return 16'd0;
            1:       return limit_ms;
            2:       return (limit_ms == 16'hFFFF) ? limit_ms : limit_ms + 16'd1;
            3:       return 16'hFFFF;
            4, 5:    return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, limit_ms));
        endcase
    endfunction

    // mostly well-formed replies with random content, some broken ones
    task automatic send_random_frame();
        int junk;
        int kind;
        int target;
        int sel;
        tx_frame.delete();
        gaps_on = ($urandom_range(0, 3) != 0);

        // leading noise; a long run pushes the header toward or past the buffer end
        sel = $urandom_range(0, 99);
        if (sel < 70)      junk = 0;
        else if (sel < 95) junk = $urandom_range(1, 6);
        else               junk = $urandom_range(50, 70);
        repeat (junk) tx_frame.push_back(junk_byte());

        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            // header never arrives
            repeat ($urandom_range(1, 10)) tx_frame.push_back(junk_byte());
        end else begin
            tx_frame.push_back(HEADER_BYTE);
            tx_frame.push_back(8'($urandom_range(0, 255)));
            if (kind < 16) begin
                // wrong message byte
                tx_frame.push_back((8'($urandom_range(0, 255)) == MESSAGE_BYTE) ?
                                   ~MESSAGE_BYTE : 8'($urandom_range(0, 255)));
                if (tx_frame[tx_frame.size() - 1] == MESSAGE_BYTE)
                    tx_frame[tx_frame.size() - 1] = ~MESSAGE_BYTE;
                repeat ($urandom_range(0, 8)) tx_frame.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 40) begin
                // error reply, named codes and arbitrary numbers
                tx_frame.push_back(MESSAGE_BYTE);
                tx_frame.push_back(ERR_FLAG_BYTE);
                tx_frame.push_back(8'($urandom_range(0, 255)));
                tx_frame.push_back(8'($urandom_range(0, 255)));
                case ($urandom_range(0, 4))
                    0:       put_digits(ERR_NUM_CALC, 3);
                    1:       put_digits(ERR_NUM_WEAK, 3);
                    2:       put_digits(ERR_NUM_STRONG, 3);
                    3:       put_digits($urandom_range(0, 999), 3);
                    default: repeat (3) tx_frame.push_back(8'($urandom_range(0, 255)));
                endcase
            end else begin
                // distance reply; raw bytes give nibbles above nine
                tx_frame.push_back(MESSAGE_BYTE);
                if ($urandom_range(0, 3) != 0)
                    put_digits($urandom_range(0, 999999), 6);
                else
                    repeat (6) tx_frame.push_back(8'($urandom_range(0, 255)));
            end
        end

        // short frame: cut anywhere after the noise
        if ($urandom_range(0, 9) == 0 && tx_frame.size() > junk + 1) begin
            target = $urandom_range(junk + 1, tx_frame.size());
            while (tx_frame.size() > target) void'(tx_frame.pop_back());
        end
        // trailing bytes past the last digit
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) tx_frame.push_back(8'($urandom_range(0, 255)));

        send_frame(pick_elapsed());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset limit boundary, lone bytes, header with nothing after it
    task automatic test_timeout_boundary();
        gaps_on = 1'b1;
        tx_frame = {8'h00};
        send_frame(TIMEOUT_RESET);                     // no header, limit not exceeded
        tx_frame = {HEADER_BYTE};
        send_frame(TIMEOUT_RESET + 16'd1);             // just over the limit
        tx_frame = {HEADER_BYTE, 8'hFF};
        send_frame(16'd0);                             // message byte missing, counts as zero
        drain_replies();
    endtask

    // wrong message byte, widest distance, a named error code
    task automatic test_reply_codes();
        gaps_on = 1'b0;
        tx_frame = {HEADER_BYTE, 8'h00, 8'h43};
        send_frame(16'd0);
        tx_frame = {HEADER_BYTE, 8'hFF, MESSAGE_BYTE};
        repeat (6) tx_frame.push_back(8'hFF);         // every nibble at fifteen
        send_frame(limit_ms);
        tx_frame = {HEADER_BYTE, 8'h00, MESSAGE_BYTE, ERR_FLAG_BYTE, 8'h00, 8'h00};
        put_digits(ERR_NUM_STRONG, 3);
        send_frame(16'hFFFF >> 6);
        drain_replies();
    endtask

    task automatic test_random_replies(bit write_limit, logic [15:0] limit, int n_bytes);
        int start;
        if (write_limit) write_timeout_limit(limit);
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) send_random_frame();
        drain_replies();
    endtask

    // long receiver hold-off while short frames keep coming, so the input backs up
    task automatic test_input_stall();
        gaps_on = 1'b0;
        ready_hold_cycles = 300;
        repeat (30) begin
            tx_frame.delete();
            if ($urandom_range(0, 1)) tx_frame.push_back(junk_byte());
            tx_frame.push_back(HEADER_BYTE);
            if ($urandom_range(0, 1)) tx_frame.push_back(8'($urandom_range(0, 255)));
            send_frame(pick_elapsed());
        end
        drain_replies();
    endtask

    initial begin
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_rx_byte    <= '0;
        s_last_byte  <= 1'b0;
        s_elapsed_ms <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_timeout_boundary();
        test_reply_codes();
        test_random_replies(1'b0, TIMEOUT_RESET, 220);
        test_random_replies(1'b1, 16'd0, 220);
        test_random_replies(1'b1, 16'hFFFF, 220);
        test_input_stall();
        test_random_replies(1'b1, 16'($urandom_range(1, 65534)), 220);
        test_random_replies(1'b1, 16'd1, 220);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
